@@ rtl/bpc_pkg.sv @@
`default_nettype none

package bpc_pkg;

	// Press counter width by default; thresholds are always 16 bits wide.
	localparam int COUNT_WIDTH_DEF = 16;
	localparam int THR_W           = 16;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENABLE           = 3'd0,
		CFG_ACTIVE_LEVEL     = 3'd1,
		CFG_LONG_PRESS_MODE  = 3'd2,
		CFG_ACCEPT_THRESHOLD = 3'd3,
		CFG_HOLD_THRESHOLD   = 3'd4,
		CFG_REPEAT_THRESHOLD = 3'd5
	} cfg_idx_t;

	localparam logic             RST_ENABLE           = 1'b1;
	localparam logic             RST_ACTIVE_LEVEL     = 1'b0;
	localparam logic             RST_LONG_PRESS_MODE  = 1'b0;
	localparam logic [THR_W-1:0] RST_ACCEPT_THRESHOLD = 16'd3;
	localparam logic [THR_W-1:0] RST_HOLD_THRESHOLD   = 16'd50;
	localparam logic [THR_W-1:0] RST_REPEAT_THRESHOLD = 16'd55;

	// Events reported for one tick.
	typedef struct packed {
		logic acting;
		logic long_press;
		logic short_press;
		logic holding;
		logic released_evt;
	} evt_t;

endpackage

`default_nettype wire

@@ rtl/button_press_classifier_unit.sv @@
// Button press classifier. Each input beat carries one sampled pin level
// (one filter tick) and produces exactly one result beat of five event
// flags. One beat is accepted per clock cycle while in_stall is low; the result
// appears in the output register in the cycle after acceptance. The classification state
// (pre-press, accepted, release-pending, long-latched flags and a
// saturating press counter) is updated in the same cycle the beat is
// accepted, so consecutive ticks need no gap. in_stall rises only while a
// result sits in the output register and out_stall is high. Configuration
// registers are written through cfg_we/cfg_index/cfg_data and take effect
// from the next accepted tick; writes to unused indexes are ignored. The
// block needs no initialisation pass after reset.
`default_nettype none

module button_press_classifier_unit #(
	parameter int COUNT_WIDTH = bpc_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration
	input  wire logic                            cfg_we,
	input  wire logic [bpc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [bpc_pkg::CFG_DATA_W-1:0]  cfg_data,
	// input channel
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic                            pin_level,
	// output channel
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic                                 acting,
	output logic                                 long_press,
	output logic                                 short_press,
	output logic                                 holding,
	output logic                                 released_evt
);

	localparam int THR_W = bpc_pkg::THR_W;
	localparam int EXT_W = (COUNT_WIDTH > THR_W) ? COUNT_WIDTH : THR_W;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	// configuration registers
	logic             enable_q;
	logic             active_level_q;
	logic             long_mode_q;
	logic [THR_W-1:0] accept_thr_q;
	logic [THR_W-1:0] hold_thr_q;
	logic [THR_W-1:0] repeat_thr_q;

	// classification state
	logic                   pre_press_q;
	logic                   accepted_q;
	logic                   rel_pending_q;
	logic                   long_latched_q;
	logic [COUNT_WIDTH-1:0] count_q;

	logic                   pre_press_d;
	logic                   accepted_d;
	logic                   rel_pending_d;
	logic                   long_latched_d;
	logic [COUNT_WIDTH-1:0] count_d;

	logic                   out_valid_q;
	bpc_pkg::evt_t          res_q;
	bpc_pkg::evt_t          evt_d;

	logic                   in_accept;
	logic                   pressed;
	logic [COUNT_WIDTH-1:0] count_inc;
	logic [EXT_W-1:0]       count_ext;
	logic [EXT_W-1:0]       hold_ext;
	logic [COUNT_WIDTH-1:0] reload;

	assign in_stall  = out_valid_q & out_stall;
	assign in_accept = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q       <= bpc_pkg::RST_ENABLE;
			active_level_q <= bpc_pkg::RST_ACTIVE_LEVEL;
			long_mode_q    <= bpc_pkg::RST_LONG_PRESS_MODE;
			accept_thr_q   <= bpc_pkg::RST_ACCEPT_THRESHOLD;
			hold_thr_q     <= bpc_pkg::RST_HOLD_THRESHOLD;
			repeat_thr_q   <= bpc_pkg::RST_REPEAT_THRESHOLD;
		end else if (cfg_we) begin
			unique case (bpc_pkg::cfg_idx_t'(cfg_index))
				bpc_pkg::CFG_ENABLE:           enable_q       <= cfg_data[0];
				bpc_pkg::CFG_ACTIVE_LEVEL:     active_level_q <= cfg_data[0];
				bpc_pkg::CFG_LONG_PRESS_MODE:  long_mode_q    <= cfg_data[0];
				bpc_pkg::CFG_ACCEPT_THRESHOLD: accept_thr_q   <= cfg_data[THR_W-1:0];
				bpc_pkg::CFG_HOLD_THRESHOLD:   hold_thr_q     <= cfg_data[THR_W-1:0];
				bpc_pkg::CFG_REPEAT_THRESHOLD: repeat_thr_q   <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	assign pressed   = (pin_level == active_level_q);
	assign count_inc = (count_q == CNT_MAX) ? count_q : count_q + 1'b1;
	assign count_ext = EXT_W'(count_inc);
	assign hold_ext  = EXT_W'(hold_thr_q);
	// clip the reload value to the counter range
	assign reload    = (hold_ext > EXT_W'(CNT_MAX)) ? CNT_MAX : COUNT_WIDTH'(hold_ext);

	always_comb begin
		pre_press_d    = pre_press_q;
		accepted_d     = accepted_q;
		rel_pending_d  = rel_pending_q;
		long_latched_d = long_latched_q;
		count_d        = count_q;
		evt_d          = '0;

		if (enable_q) begin
			if (pressed) begin
				evt_d.acting = 1'b1;
				if (!pre_press_q && !accepted_q) begin
					pre_press_d = 1'b1;
				end else begin
					count_d = count_inc;
					if (!accepted_q && count_ext >= EXT_W'(accept_thr_q)) begin
						pre_press_d   = 1'b0;
						accepted_d    = 1'b1;
						rel_pending_d = 1'b0;
					end
					if (accepted_d && count_ext >= hold_ext) begin
						if (long_mode_q && !long_latched_q) begin
							long_latched_d   = 1'b1;
							evt_d.long_press = 1'b1;
						end else if (!long_mode_q &&
						             count_ext >= EXT_W'(repeat_thr_q)) begin
							count_d           = reload;
							evt_d.short_press = 1'b1;
						end
						evt_d.holding = 1'b1;
					end
				end
			end else begin
				if (pre_press_q) begin
					// bounce before acceptance: drop the pre-press
					pre_press_d    = 1'b0;
					long_latched_d = 1'b0;
				end else if (accepted_q) begin
					if (!rel_pending_q) begin
						rel_pending_d = 1'b1;
					end else begin
						pre_press_d        = 1'b0;
						accepted_d         = 1'b0;
						rel_pending_d      = 1'b0;
						evt_d.short_press  = ~long_latched_q;
						evt_d.released_evt = 1'b1;
						count_d            = '0;
						long_latched_d     = 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_press_q    <= 1'b0;
			accepted_q     <= 1'b0;
			rel_pending_q  <= 1'b0;
			long_latched_q <= 1'b0;
			count_q        <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (in_accept) begin
				pre_press_q    <= pre_press_d;
				accepted_q     <= accepted_d;
				rel_pending_q  <= rel_pending_d;
				long_latched_q <= long_latched_d;
				count_q        <= count_d;
				out_valid_q    <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// hold the result beat while stalled
	always_ff @(posedge clk) begin
		if (in_accept) begin
			res_q <= evt_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign acting       = res_q.acting;
	assign long_press   = res_q.long_press;
	assign short_press  = res_q.short_press;
	assign holding      = res_q.holding;
	assign released_evt = res_q.released_evt;

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(pre_press_q && accepted_q))
		else $error("pre-press and accepted set together");

	a_pending_needs_press: assert property (@(posedge clk) disable iff (!arst_n)
		(rel_pending_q || long_latched_q) |-> accepted_q)
		else $error("release pending or long latch without accepted press");

	a_long_short_apart: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(res_q.long_press && res_q.short_press))
		else $error("long and short press in one beat");

	a_release_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.released_evt) |-> (!accepted_q && count_q == '0))
		else $error("press state left after release event");

	a_holding_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.holding) |-> accepted_q)
		else $error("holding reported without accepted press");

endmodule

`default_nettype wire

@@ bench/button_press_classifier_unit_tb.sv @@
`default_nettype none

module button_press_classifier_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          CLK_HALF   = 1;
	localparam bit [15:0]   THR_TOP    = 16'hFFFF;

	logic                            clk          = 1'b0;
	logic                            arst_n       = 1'b0;
	logic                            cfg_we       = 1'b0;
	logic [bpc_pkg::CFG_IDX_W-1:0]   cfg_index    = '0;
	logic [bpc_pkg::CFG_DATA_W-1:0]  cfg_data     = '0;
	logic                            in_valid     = 1'b0;
	logic                            in_stall;
	logic                            pin_level    = 1'b0;
	logic                            out_valid;
	logic                            out_stall    = 1'b0;
	logic                            acting;
	logic                            long_press;
	logic                            short_press;
	logic                            holding;
	logic                            released_evt;

	int unsigned            send_idle_pct = 0;
	int unsigned            recv_stall_pct = 0;
	int unsigned            settings_done = 0;

	button_press_classifier_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.pin_level    (pin_level),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.acting       (acting),
		.long_press   (long_press),
		.short_press  (short_press),
		.holding      (holding),
		.released_evt (released_evt)
	);

	// Own copy of the classifier: flags, counter and register settings,
	// plus the events each accepted tick should produce, oldest first.
	class press_event_tracker;
		bit         en;
		bit         level;
		bit         long_mode;
		bit [15:0]  accept_thr;
		bit [15:0]  hold_thr;
		bit [15:0]  repeat_thr;
		bit         pre;
		bit         acc;
		bit         rel_pend;
		bit         long_lat;
		bit [15:0]  count;
		bpc_pkg::evt_t due_events[$];
		int unsigned errors;
		int unsigned ticks;
		int unsigned checked;

		function new();
			en         = bpc_pkg::RST_ENABLE;
			level      = bpc_pkg::RST_ACTIVE_LEVEL;
			long_mode  = bpc_pkg::RST_LONG_PRESS_MODE;
			accept_thr = bpc_pkg::RST_ACCEPT_THRESHOLD;
			hold_thr   = bpc_pkg::RST_HOLD_THRESHOLD;
			repeat_thr = bpc_pkg::RST_REPEAT_THRESHOLD;
			pre        = 1'b0;
			acc        = 1'b0;
			rel_pend   = 1'b0;
			long_lat   = 1'b0;
			count      = '0;
			errors     = 0;
			ticks      = 0;
			checked    = 0;
		endfunction

		function void set_reg(bpc_pkg::cfg_idx_t idx, bit [15:0] val);
			case (idx)
				bpc_pkg::CFG_ENABLE:           en         = val[0];
				bpc_pkg::CFG_ACTIVE_LEVEL:     level      = val[0];
				bpc_pkg::CFG_LONG_PRESS_MODE:  long_mode  = val[0];
				bpc_pkg::CFG_ACCEPT_THRESHOLD: accept_thr = val;
				bpc_pkg::CFG_HOLD_THRESHOLD:   hold_thr   = val;
				bpc_pkg::CFG_REPEAT_THRESHOLD: repeat_thr = val;
				default: ;
			endcase
		endfunction

		function void note_tick(bit pin);
			bpc_pkg::evt_t e;
			e = '0;
			ticks++;
			if (en) begin
				if (pin == level) begin
					e.acting = 1'b1;
					if (!pre && !acc) begin
						pre = 1'b1;
					end else begin
						if (count != THR_TOP)
							count++;
						if (!acc && count >= accept_thr) begin
							pre      = 1'b0;
							acc      = 1'b1;
							rel_pend = 1'b0;
						end
						if (acc && count >= hold_thr) begin
							if (long_mode && !long_lat) begin
								long_lat     = 1'b1;
								e.long_press = 1'b1;
							end else if (!long_mode && count >= repeat_thr) begin
								// reload the counter so the next repeat is a fixed gap away
								count         = hold_thr;
								e.short_press = 1'b1;
							end
							e.holding = 1'b1;
						end
					end
				end else if (pre) begin
					pre      = 1'b0;
					long_lat = 1'b0;
				end else if (acc) begin
					if (!rel_pend) begin
						rel_pend = 1'b1;
					end else begin
						pre            = 1'b0;
						acc            = 1'b0;
						rel_pend       = 1'b0;
						e.short_press  = !long_lat;
						e.released_evt = 1'b1;
						count          = '0;
						long_lat       = 1'b0;
					end
				end
			end
			due_events.push_back(e);
		endfunction

		function void check_events(bpc_pkg::evt_t got);
			bpc_pkg::evt_t want;
			string field_name [5] = '{"released_evt", "holding", "short_press",
				"long_press", "acting"};
			if (due_events.size() == 0) begin
				errors++;
				$display("%0t: result %b arrived with nothing expected", $time, got);
			end else begin
				want = due_events.pop_front();
				checked++;
				for (int i = 0; i < 5; i++) begin
					if (want[i] !== got[i]) begin
						errors++;
						$display("%0t: %s expected %b actual %b", $time, field_name[i],
							want[i], got[i]);
					end
				end
			end
		endfunction
	endclass

	press_event_tracker events = new();

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	always @(negedge clk)
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			events.check_events({acting, long_press, short_press, holding, released_evt});
	end

	task automatic send_tick(input bit pin);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		pin_level <= pin;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		events.note_tick(pin);
	endtask

	task automatic send_pattern(input string bits);
		for (int i = 0; i < bits.len(); i++)
			send_tick(bits[i] == "1");
	endtask

	// Hold the sender until every expected result has arrived.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (events.due_events.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input bpc_pkg::cfg_idx_t idx, input bit [15:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		events.set_reg(idx, val);
	endtask

	task automatic apply_regs(input bit en, input bit lvl, input bit lm,
		input bit [15:0] a, input bit [15:0] h, input bit [15:0] r);
		drain();
		write_reg(bpc_pkg::CFG_ENABLE, {15'd0, en});
		write_reg(bpc_pkg::CFG_ACTIVE_LEVEL, {15'd0, lvl});
		write_reg(bpc_pkg::CFG_LONG_PRESS_MODE, {15'd0, lm});
		write_reg(bpc_pkg::CFG_ACCEPT_THRESHOLD, a);
		write_reg(bpc_pkg::CFG_HOLD_THRESHOLD, h);
		write_reg(bpc_pkg::CFG_REPEAT_THRESHOLD, r);
		@(negedge clk);
		cfg_we <= 1'b0;
		settings_done++;
	endtask

	task automatic press_run(input int unsigned n, input bit pressed);
		for (int i = 0; i < n; i++)
			send_tick(pressed ? events.level : !events.level);
	endtask

	// Mostly whole presses of random length; some bounces and plain noise.
	task automatic random_presses(input int unsigned n);
		int unsigned sent;
		int unsigned reach;
		int unsigned run;
		int unsigned k;
		int unsigned pick;
		sent  = 0;
		reach = (events.repeat_thr > events.hold_thr) ? 32'(events.repeat_thr) :
			32'(events.hold_thr);
		if (reach > 56)
			reach = 56;
		reach += 8;
		while (sent < n) begin
			pick = $urandom_range(0, 99);
			run  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(1, reach);
			if (pick < 12) begin
				k = $urandom_range(1, 6);
				for (int i = 0; i < k; i++)
					send_tick(1'($urandom_range(0, 1)));
				sent += k;
			end else if (pick < 24) begin
				k = $urandom_range(1, 4);
				press_run(run, 1'b1);
				press_run(1, 1'b0);
				press_run(k, 1'b1);
				press_run(2, 1'b0);
				sent += run + k + 3;
			end else begin
				k = $urandom_range(1, 3);
				press_run(run, 1'b1);
				press_run(k, 1'b0);
				sent += run + k;
			end
			if ($urandom_range(0, 199) == 0)
				drain();
		end
	endtask

	initial begin
		bit [15:0] a;
		bit [15:0] h;
		bit [15:0] r;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct  = 21;
		recv_stall_pct = 83;

		// Rejected pre-press, accept, bounce during release, hold, repeat, release.
		apply_regs(1'b1, 1'b0, 1'b0, 16'd2, 16'd4, 16'd5);
		send_pattern("101000100011");
		// Zero thresholds in long-press mode with an active-high pin.
		apply_regs(1'b1, 1'b1, 1'b1, 16'd0, 16'd0, 16'd0);
		send_pattern("11100");
		// Disabled: no events at all.
		apply_regs(1'b0, 1'b0, 1'b0, 16'd2, 16'd4, 16'd5);
		send_pattern("01");

		for (int p = 0; p < 18; p++) begin
			send_idle_pct  = (p < 6) ? 21 : (p < 12) ? 83 : 0;
			recv_stall_pct = (p < 6) ? 83 : (p < 12) ? 21 : 0;
			if (p % 6 == 0) begin
				apply_regs(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					16'd0, 16'd0, 16'd0);
			end else if (p == 1) begin
				apply_regs(1'b1, 1'b1, 1'b0, THR_TOP, THR_TOP, THR_TOP);
			end else if (p == 7) begin
				apply_regs(1'b0, 1'b1, 1'b1, 16'd3, 16'd6, 16'd8);
			end else if (p == 13) begin
				// thresholds out of their usual order
				a = 16'($urandom_range(6, 12));
				h = 16'($urandom_range(0, a));
				r = 16'($urandom_range(0, h));
				apply_regs(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					a, h, r);
			end else begin
				if ($urandom_range(0, 4) == 0) begin
					a = 16'($urandom_range(0, 20));
					h = 16'($urandom_range(0, 20));
					r = 16'($urandom_range(0, 20));
				end else begin
					a = 16'($urandom_range(0, 8));
					h = 16'(a + $urandom_range(0, 12));
					r = 16'(h + $urandom_range(0, 10));
				end
				apply_regs($urandom_range(0, 9) != 0, 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), a, h, r);
			end
			random_presses(65);
		end

		drain();
		repeat (10) @(posedge clk);
		if (events.due_events.size() != 0) begin
			events.errors++;
			$display("%0t: %0d results never arrived", $time, events.due_events.size());
		end
		$display("Ran %0d ticks (%0d results checked) across %0d register settings,",
			events.ticks, events.checked, settings_done);
		$display("including zero and top thresholds, disabled, both levels and modes.");
		if (events.errors == 0) begin
			$display("button_press_classifier_unit_tb: PASS");
		end else begin
			$display("button_press_classifier_unit_tb: FAIL");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("%0t: run timed out", $time);
		$display("button_press_classifier_unit_tb: FAIL");
		$finish;
	end

endmodule

`default_nettype wire

@@ button_press_classifier_unit.f @@
rtl/bpc_pkg.sv
rtl/button_press_classifier_unit.sv
bench/button_press_classifier_unit_tb.sv
